/* design/fbpa_pkg.sv */
package fbpa_pkg;

   // Pool geometry. Both values must be powers of two.
   localparam int POOL_BLOCKS  = 4096;
   localparam int CHUNK_BLOCKS = 512;

   localparam int IDX_W       = $clog2(POOL_BLOCKS);
   localparam int FILL_W      = IDX_W + 1;
   localparam int CHUNK_SHIFT = $clog2(CHUNK_BLOCKS);
   localparam int MAX_CHUNKS  = POOL_BLOCKS / CHUNK_BLOCKS;
   localparam int CHUNK_CNT_W = $clog2(MAX_CHUNKS + 1);

   localparam int BSZ_W  = 17;
   localparam int MAXB_W = 13;
   localparam int OFS_W  = 28;
   localparam int STAT_W = 2;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_BYTES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_QUOTA = 2'd1;

   localparam logic [BSZ_W-1:0]  UNIT_BYTES_RESET  = 17'd1024;
   localparam logic [MAXB_W-1:0] BLOCK_QUOTA_RESET = 13'd4096;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [STAT_W-1:0] ST_FREE_FULL = 2'd2;

   // A decided request waiting for its offset to be computed.
   typedef struct packed {
      logic              valid;
      logic [STAT_W-1:0] status;
      logic              pop;
      logic [IDX_W-1:0]  index;
   } pend_type;

endpackage

/* design/fixed_block_pool_allocator.sv */
// Fixed-size block pool allocator. Each request either allocates a block
// (kind 0) or frees one (kind 1) and yields exactly one response carrying a
// status, the granted handle and its byte offset (handle times the block
// size register, low 28 bits). Allocation prefers the oldest freed handle,
// then the spare blocks of the current 512-block chunk from the top down,
// then block 0 of a new chunk until the block quota register, rounded up to
// whole chunks, is used up. One request is in
// work at a time: it is accepted, decided in the same edge, and passes to the
// response register on the next cycle when the response side keeps up; no
// new request is accepted before it has passed. The freed-handle queue memory
// has a registered read that feeds the offset multiplier. A finished response
// may wait in its register while the next request is accepted.
// The queue memory needs no clearing after reset; the configuration port is
// always ready and should be written only while no request is in work.
module fixed_block_pool_allocator
   import fbpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [IDX_W-1:0]     req_block_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [IDX_W-1:0]     rsp_granted_index,
   output logic [OFS_W-1:0]     rsp_byte_offset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   logic [BSZ_W-1:0]  unit_bytes_ff, unit_bytes_in;
   logic [MAXB_W-1:0] block_quota_ff, block_quota_in;

   pend_type          pend;
   logic              take;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic              ram_re;
   logic [IDX_W-1:0]  ram_raddr;
   logic [IDX_W-1:0]  ram_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      unit_bytes_in  = unit_bytes_ff;
      block_quota_in = block_quota_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_UNIT_BYTES:  unit_bytes_in  = csr_data[BSZ_W-1:0];
            CSR_BLOCK_QUOTA: block_quota_in = csr_data[MAXB_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_bytes_ff  <= UNIT_BYTES_RESET;
         block_quota_ff <= BLOCK_QUOTA_RESET;
      end else begin
         unit_bytes_ff  <= unit_bytes_in;
         block_quota_ff <= block_quota_in;
      end
   end

   fbpa_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .block_quota     (block_quota_ff),
      .take            (take),
      .pend            (pend),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_re          (ram_re),
      .ram_raddr       (ram_raddr)
   );

   // The freed handle goes straight from the request port to the memory.
   fbpa_fifo_ram u_fifo_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_block_index),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   fbpa_result u_result (
      .clock             (clock),
      .reset             (reset),
      .pend              (pend),
      .ram_rdata         (ram_rdata),
      .unit_bytes        (unit_bytes_ff),
      .take              (take),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_byte_offset   (rsp_byte_offset)
   );

endmodule

/* design/fbpa_fifo_ram.sv */
module fbpa_fifo_ram
   import fbpa_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [IDX_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [IDX_W-1:0] rd_data
);

   logic [IDX_W-1:0] mem [POOL_BLOCKS];
   logic [IDX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/fbpa_ctrl.sv */
module fbpa_ctrl
   import fbpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [MAXB_W-1:0] block_quota,
   input  logic              take,
   output pend_type          pend,
   output logic              ram_we,
   output logic [IDX_W-1:0]  ram_waddr,
   output logic              ram_re,
   output logic [IDX_W-1:0]  ram_raddr
);

   localparam int LIM_W = MAXB_W + 1 - CHUNK_SHIFT;

   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       tail_ff, tail_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [CHUNK_CNT_W-1:0] chunks_ff, chunks_in;
   logic [CHUNK_SHIFT-1:0] spare_ff, spare_in;
   pend_type               pend_ff, pend_in;

   logic                   accept;
   logic [MAXB_W:0]        lim_sum;
   logic [LIM_W-1:0]       lim_raw;
   logic [CHUNK_CNT_W-1:0] limit;

   assign req_ready = !pend_ff.valid;
   assign accept    = req_valid && req_ready;
   assign pend      = pend_ff;
   assign ram_waddr = tail_ff;
   assign ram_raddr = head_ff;

   // Chunk limit is the quota rounded up to whole chunks, capped at the pool.
   assign lim_sum = {1'b0, block_quota} + (MAXB_W + 1)'(CHUNK_BLOCKS - 1);
   assign lim_raw = lim_sum[MAXB_W:CHUNK_SHIFT];
   assign limit   = (lim_raw > LIM_W'(MAX_CHUNKS)) ? CHUNK_CNT_W'(MAX_CHUNKS)
                                                   : CHUNK_CNT_W'(lim_raw);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      chunks_in = chunks_ff;
      spare_in  = spare_ff;
      pend_in   = pend_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      if (take) begin
         pend_in.valid = 1'b0;
      end
      if (accept) begin
         pend_in.valid  = 1'b1;
         pend_in.status = ST_OK;
         pend_in.pop    = 1'b0;
         pend_in.index  = '0;
         if (req_kind == KIND_FREE) begin
            if (fill_ff == FILL_W'(POOL_BLOCKS)) begin
               pend_in.status = ST_FREE_FULL;
            end else begin
               ram_we  = 1'b1;
               tail_in = tail_ff + 1'b1;
               fill_in = fill_ff + 1'b1;
            end
         end else if (fill_ff != '0) begin
            // The handle arrives from the queue memory on the next cycle.
            ram_re      = 1'b1;
            pend_in.pop = 1'b1;
            head_in     = head_ff + 1'b1;
            fill_in     = fill_ff - 1'b1;
         end else if (spare_ff != '0 && chunks_ff != '0) begin
            pend_in.index = (IDX_W'(chunks_ff - 1'b1) << CHUNK_SHIFT) | IDX_W'(spare_ff);
            spare_in      = spare_ff - 1'b1;
         end else if (chunks_ff < limit) begin
            pend_in.index = IDX_W'(chunks_ff) << CHUNK_SHIFT;
            chunks_in     = chunks_ff + 1'b1;
            spare_in      = CHUNK_SHIFT'(CHUNK_BLOCKS - 1);
         end else begin
            pend_in.status = ST_EXHAUSTED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         chunks_ff     <= '0;
         spare_ff      <= '0;
         pend_ff.valid <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         chunks_ff     <= chunks_in;
         spare_ff      <= spare_in;
         pend_ff.valid <= pend_in.valid;
      end
      pend_ff.status <= pend_in.status;
      pend_ff.pop    <= pend_in.pop;
      pend_ff.index  <= pend_in.index;
   end

endmodule

/* design/fbpa_result.sv */
module fbpa_result
   import fbpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  pend_type          pend,
   input  logic [IDX_W-1:0]  ram_rdata,
   input  logic [BSZ_W-1:0]  unit_bytes,
   output logic              take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [IDX_W-1:0]  rsp_granted_index,
   output logic [OFS_W-1:0]  rsp_byte_offset
);

   logic                      valid_ff, valid_in;
   logic [STAT_W-1:0]         status_ff;
   logic [IDX_W-1:0]          index_ff;
   logic [OFS_W-1:0]          offset_ff;
   logic [IDX_W-1:0]          index;
   logic [IDX_W+BSZ_W-1:0]    product;

   assign take    = pend.valid && (!valid_ff || rsp_ready);
   assign index   = pend.pop ? ram_rdata : pend.index;
   assign product = index * unit_bytes;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         status_ff <= pend.status;
         index_ff  <= index;
         offset_ff <= product[OFS_W-1:0];
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_granted_index = index_ff;
   assign rsp_byte_offset   = offset_ff;

endmodule

/* sim/fbpa_pool_checker.sv */
module fbpa_pool_checker
   import fbpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_kind,
   input  logic [IDX_W-1:0]     req_block_index,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [STAT_W-1:0]    rsp_status,
   input  logic [IDX_W-1:0]     rsp_granted_index,
   input  logic [OFS_W-1:0]     rsp_byte_offset,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output int                   fail_count,
   output int                   open_count
);

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  index;
      logic [OFS_W-1:0]  offset;
   } grant_result_type;

   grant_result_type grants_due[$];

   // Shadow of the allocator state.
   logic [IDX_W-1:0]  freed_ring [POOL_BLOCKS];
   int                ring_head;
   int                ring_tail;
   int                ring_fill;
   int                chunks_open;
   int                spare_left;
   logic [BSZ_W-1:0]  block_bytes;
   logic [MAXB_W-1:0] block_limit;

   function automatic grant_result_type make_result(input logic [STAT_W-1:0] st,
                                                    input logic [IDX_W-1:0] idx);
      logic [IDX_W+BSZ_W-1:0] prod;
      grant_result_type r;
      prod = {{BSZ_W{1'b0}}, idx} * {{IDX_W{1'b0}}, block_bytes};
      r.status = st;
      r.index  = idx;
      r.offset = prod[OFS_W-1:0];
      return r;
   endfunction

   function automatic grant_result_type predict_grant(input logic kind,
                                                      input logic [IDX_W-1:0] handle);
      int limit;
      logic [IDX_W-1:0] got;
      if (kind == KIND_FREE) begin
         if (ring_fill >= POOL_BLOCKS)
            return make_result(ST_FREE_FULL, '0);
         freed_ring[ring_tail] = handle;
         ring_tail = (ring_tail + 1) % POOL_BLOCKS;
         ring_fill++;
         return make_result(ST_OK, '0);
      end
      if (ring_fill > 0) begin
         got = freed_ring[ring_head];
         ring_head = (ring_head + 1) % POOL_BLOCKS;
         ring_fill--;
         return make_result(ST_OK, got);
      end
      if (spare_left > 0 && chunks_open > 0) begin
         got = IDX_W'((chunks_open - 1) * CHUNK_BLOCKS + spare_left);
         spare_left--;
         return make_result(ST_OK, got);
      end
      // The chunk limit follows the current quota whenever a new chunk is needed.
      limit = (int'(block_limit) + CHUNK_BLOCKS - 1) / CHUNK_BLOCKS;
      if (limit > MAX_CHUNKS)
         limit = MAX_CHUNKS;
      if (chunks_open < limit) begin
         got = IDX_W'(chunks_open * CHUNK_BLOCKS);
         chunks_open++;
         spare_left = CHUNK_BLOCKS - 1;
         return make_result(ST_OK, got);
      end
      return make_result(ST_EXHAUSTED, '0);
   endfunction

   task automatic report(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      grant_result_type want;
      if (reset) begin
         ring_head   = 0;
         ring_tail   = 0;
         ring_fill   = 0;
         chunks_open = 0;
         spare_left  = 0;
         block_bytes = UNIT_BYTES_RESET;
         block_limit = BLOCK_QUOTA_RESET;
         fail_count  = 0;
         grants_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (grants_due.size() == 0) begin
               report($sformatf("unexpected response status=%0d index=%0d offset=%0d",
                                rsp_status, rsp_granted_index, rsp_byte_offset));
            end else begin
               want = grants_due.pop_front();
               if (want.status !== rsp_status || want.index !== rsp_granted_index ||
                   want.offset !== rsp_byte_offset)
                  report($sformatf({"expected status=%0d index=%0d offset=%0d, ",
                                    "got status=%0d index=%0d offset=%0d"},
                                   want.status, want.index, want.offset,
                                   rsp_status, rsp_granted_index, rsp_byte_offset));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_UNIT_BYTES:  block_bytes = csr_data[BSZ_W-1:0];
               CSR_BLOCK_QUOTA: block_limit = csr_data[MAXB_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            grants_due.push_back(predict_grant(req_kind, req_block_index));
      end
      open_count = grants_due.size();
   end

endmodule

/* sim/fixed_block_pool_allocator_tb.sv */
module fixed_block_pool_allocator_tb;
   import fbpa_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [IDX_W-1:0] TOP_HANDLE = '1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_kind = KIND_ALLOC;
   logic [IDX_W-1:0]     req_block_index = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STAT_W-1:0]    rsp_status;
   logic [IDX_W-1:0]     rsp_granted_index;
   logic [OFS_W-1:0]     rsp_byte_offset;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   int fail_count;
   int open_count;
   int idle_cycles = 0;
   bit steady = 1'b0;

   always #10 clock = ~clock;

   fixed_block_pool_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_block_index   (req_block_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_byte_offset   (rsp_byte_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   fbpa_pool_checker pool_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_block_index   (req_block_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_byte_offset   (rsp_byte_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .open_count        (open_count)
   );

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 25);
   end

   // Ends the run when no channel has moved anything for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("fixed_block_pool_allocator_tb NOT OK");
         $finish;
      end
   end

   function automatic logic [IDX_W-1:0] pick_handle();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return TOP_HANDLE;
         default: return IDX_W'($urandom_range(0, POOL_BLOCKS - 1));
      endcase
   endfunction

   // Valid is left high after acceptance so that a following request can
   // reuse it without a drop; drain lowers it, and the next call may drop it first.
   task automatic send_request(input logic kind, input logic [IDX_W-1:0] handle);
      if (!steady && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_block_index <= handle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] value, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (last)
         csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random(input int count, input int alloc_pct, input bit no_idle);
      logic [CSR_DAT_W-1:0] bytes;
      logic [CSR_DAT_W-1:0] limit;
      drain();
      case ($urandom_range(0, 5))
         0:       bytes = '0;
         1:       bytes = 17'd1;
         2:       bytes = 17'd1024;
         3:       bytes = 17'd65536;
         4:       bytes = '1;
         default: bytes = CSR_DAT_W'($urandom_range(1, 65536));
      endcase
      case ($urandom_range(0, 6))
         0:       limit = '0;
         1:       limit = 17'd1;
         2:       limit = 17'd512;
         3:       limit = 17'd513;
         4:       limit = 17'd4096;
         5:       limit = 17'd8191;
         default: limit = CSR_DAT_W'($urandom_range(0, 8191));
      endcase
      csr_write(CSR_UNIT_BYTES, bytes, 1'b0);
      csr_write(CSR_BLOCK_QUOTA, limit, 1'b1);
      steady <= no_idle;
      repeat (count)
         send_request(($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE,
                      pick_handle());
      steady <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With no chunk allowed, only freed handles can be granted.
      csr_write(CSR_BLOCK_QUOTA, '0, 1'b1);
      send_request(KIND_ALLOC, '0);
      send_request(KIND_FREE, TOP_HANDLE);
      send_request(KIND_ALLOC, '0);
      drain();

      csr_write(CSR_UNIT_BYTES, 17'd65536, 1'b0);
      csr_write(CSR_BLOCK_QUOTA, 17'd1, 1'b1);
      repeat (3) send_request(KIND_ALLOC, TOP_HANDLE);
      send_request(KIND_FREE, '0);
      send_request(KIND_FREE, TOP_HANDLE);
      send_request(KIND_FREE, TOP_HANDLE);
      send_request(KIND_FREE, 12'hAAA);
      send_request(KIND_FREE, 12'h555);
      repeat (6) send_request(KIND_ALLOC, '0);
      drain();

      // Lowering the limit still leaves the open chunk's spares available.
      csr_write(CSR_UNIT_BYTES, '1, 1'b0);
      csr_write(CSR_UNMAPPED, '1, 1'b0);
      csr_write(CSR_BLOCK_QUOTA, '0, 1'b1);
      send_request(KIND_FREE, TOP_HANDLE);
      send_request(KIND_ALLOC, '0);
      send_request(KIND_ALLOC, '0);
      drain();
      csr_write(CSR_UNIT_BYTES, '0, 1'b1);
      send_request(KIND_ALLOC, '0);

      run_random(250, 65, 1'b0);
      run_random(250, 65, 1'b1);
      run_random(250, 65, 1'b0);

      run_random(250, 50, 1'b0);
      run_random(250, 50, 1'b0);
      run_random(250, 50, 1'b0);

      drain();
      if (fail_count == 0 && open_count == 0)
         $display("fixed_block_pool_allocator_tb OK");
      else
         $display("fixed_block_pool_allocator_tb NOT OK");
      $finish;
   end

endmodule

/* fixed_block_pool_allocator.f */
design/fbpa_pkg.sv
design/fbpa_fifo_ram.sv
design/fbpa_ctrl.sv
design/fbpa_result.sv
design/fixed_block_pool_allocator.sv
sim/fbpa_pool_checker.sv
sim/fixed_block_pool_allocator_tb.sv
